/* sv/stbk_pkg.sv */
package stbk_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int ID_W           = 8;
    localparam int DATA_W         = 32;
    localparam int TYPE_MAP_W     = 16;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_INVALID = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_RUNNING = 2'd1,
        ST_EXPIRED = 2'd2
    } t_status;

    // One timer entry as held in the bank memory
    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   stamp;
        logic [DATA_W-1:0]   elapsed;
        logic [DATA_W-1:0]   limit;
    } t_entry;

    // Request as registered ahead of the execute logic
    typedef struct packed {
        t_req                req;
        logic                id_ok;
        logic                use_ms;
        logic [DATA_W-1:0]   timeout;
        logic [DATA_W-1:0]   fine;
        logic [DATA_W-1:0]   tick;
    } t_s1_req;

    typedef struct packed {
        logic                error;
        logic                report_valid;
        t_status             state;
        logic [DATA_W-1:0]   elapsed;
    } t_result;

    typedef struct packed {
        t_result             res;
        logic                wr_en;
        t_entry              wr_entry;
    } t_exec_out;

endpackage

/* sv/stbk_exec.sv */
module stbk_exec
    import stbk_pkg::*;
(
    input  t_s1_req   i_req,
    input  t_entry    i_entry,
    output t_exec_out o_exec
);

    logic [DATA_W-1:0] ms_diff;
    logic [DATA_W-1:0] fine_diff;
    logic [DATA_W-1:0] elapsed;
    logic              refuse;
    t_entry            nxt;

    assign ms_diff   = i_req.tick - i_entry.stamp;
    assign fine_diff = i_entry.stamp - i_req.fine;
    // Fine counter runs down at twice the 0.1 us rate: halve the difference
    assign elapsed   = i_req.use_ms ? ms_diff : (fine_diff >> 1);

    always_comb begin
        nxt                       = i_entry;
        refuse                    = 1'b0;
        o_exec.wr_en              = 1'b0;
        o_exec.res.error          = 1'b0;
        if (!i_req.id_ok) begin
            refuse = 1'b1;
        end else begin
            unique case (i_req.req)
                REQ_START: begin
                    if (i_entry.status == ST_RUNNING) begin
                        refuse = 1'b1;
                    end else begin
                        nxt.status   = ST_RUNNING;
                        nxt.limit    = i_req.timeout;
                        nxt.stamp    = i_req.use_ms ? i_req.tick : i_req.fine;
                        o_exec.wr_en = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    nxt          = '0;
                    o_exec.wr_en = 1'b1;
                end
                REQ_CHECK: begin
                    if (i_entry.status != ST_STOPPED) begin
                        nxt.elapsed = elapsed;
                        if (i_entry.status == ST_RUNNING && elapsed >= i_entry.limit) begin
                            nxt.status = ST_EXPIRED;
                        end
                        o_exec.wr_en = 1'b1;
                    end
                end
                REQ_INVALID: begin
                    o_exec.res.error = 1'b1;
                end
                default: begin
                    o_exec.res.error = 1'b1;
                end
            endcase
        end

        o_exec.wr_entry = nxt;
        if (refuse) begin
            o_exec.res.error        = 1'b1;
            o_exec.res.report_valid = 1'b0;
            o_exec.res.state        = ST_STOPPED;
            o_exec.res.elapsed      = '0;
        end else begin
            o_exec.res.report_valid = 1'b1;
            o_exec.res.state        = nxt.status;
            o_exec.res.elapsed      = nxt.elapsed;
        end
    end

endmodule

/* sv/software_timer_bank_core.sv */
// Chan | Handshake                 | Beat fields
// -----+---------------------------+-------------------------------------------------------
// in   | i_in_valid / o_in_stall   | req_type, timer_id, timeout_value, fine_count, ms_tick
// out  | o_out_valid / i_out_stall | error, report_valid, timer_state, elapsed_time
// cfg  | i_cfg_wr_en, no stall     | timer_type_map
//
// Request to report: a registered read of the timer bank, then the read-modify-write into
// the result register. A request can be accepted every cycle the middle stage is not held;
// a write landing as the next request is read is forwarded around the bank memory.
// Synchronous active-low reset empties the pipeline and clears the per-timer valid bits,
// so unwritten timers read as stopped with zero stamp, elapsed and limit; no clearing pass.
// A stalled report holds the result register; requests stall only behind a full middle stage.
module software_timer_bank_core
    import stbk_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [TYPE_MAP_W-1:0] i_cfg_wr_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [ID_W-1:0]       i_timer_id,
    input  logic [DATA_W-1:0]     i_timeout_value,
    input  logic [DATA_W-1:0]     i_fine_count,
    input  logic [DATA_W-1:0]     i_ms_tick,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_error,
    output logic                  o_report_valid,
    output logic [1:0]            o_timer_state,
    output logic [DATA_W-1:0]     o_elapsed_time
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Timer bank: one entry per timer, registered read
    t_entry                 r_bank [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  r_vld;

    logic [TYPE_MAP_W-1:0]  r_type_map;

    // Middle stage
    logic                   r_s1_valid;
    t_s1_req                r_s1;
    logic [IDX_W-1:0]       r_s1_idx;
    logic                   r_s1_ent_vld;
    t_entry                 r_rd_entry;
    logic                   r_byp;
    t_entry                 r_byp_entry;

    // Output register
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_acc;
    logic                   s1_adv;
    logic                   id_ok;
    logic                   use_ms;
    logic [IDX_W-1:0]       rd_idx;
    logic                   wr_en;
    t_entry                 cur_entry;
    t_s1_req                n_s1;
    t_exec_out              exec;

    // Middle stage drains whenever the output register is free or being taken
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign id_ok  = {1'b0, i_timer_id} < (ID_W + 1)'(NUM_TIMERS);
    assign rd_idx = IDX_W'(i_timer_id);
    // Timers numbered beyond the type map always count on the fine base
    assign use_ms = (i_timer_id < ID_W'(TYPE_MAP_W)) &&
                    r_type_map[i_timer_id[$clog2(TYPE_MAP_W)-1:0]];

    always_comb begin
        n_s1.req     = t_req'(i_req_type);
        n_s1.id_ok   = id_ok;
        n_s1.use_ms  = use_ms;
        n_s1.timeout = i_timeout_value;
        n_s1.fine    = i_fine_count;
        n_s1.tick    = i_ms_tick;
    end

    // Pick the freshest copy of the entry: forwarded write, bank, or reset value
    always_comb begin
        if (r_byp) begin
            cur_entry = r_byp_entry;
        end else if (r_s1_ent_vld) begin
            cur_entry = r_rd_entry;
        end else begin
            cur_entry = '0;
        end
    end

    stbk_exec u_exec (
        .i_req   (r_s1),
        .i_entry (cur_entry),
        .o_exec  (exec)
    );

    assign wr_en = s1_adv && exec.wr_en;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_map <= '0;
        end else if (i_cfg_wr_en) begin
            r_type_map <= i_cfg_wr_data;
        end
    end

    // Bank memory: write back on drain, read on acceptance
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bank[r_s1_idx] <= exec.wr_entry;
        end
        if (in_acc && id_ok) begin
            r_rd_entry <= r_bank[rd_idx];
        end
    end

    // Valid bits: a timer never written reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1_idx] <= 1'b1;
        end
    end

    // Middle stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Middle stage payload; catch a write to the same timer landing this edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1         <= n_s1;
            r_s1_idx     <= rd_idx;
            r_s1_ent_vld <= id_ok && r_vld[rd_idx];
            r_byp        <= wr_en && id_ok && (r_s1_idx == rd_idx);
            r_byp_entry  <= exec.wr_entry;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= exec.res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_error        = r_out.error;
    assign o_report_valid = r_out.report_valid;
    assign o_timer_state  = r_out.state;
    assign o_elapsed_time = r_out.elapsed;

`ifndef SYNTH
    // Request side stalls only behind a full middle stage blocked by the report side
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("request stalled without a blocked pipeline");

    // A held middle stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1) && $stable(r_s1_idx)))
        else $error("middle stage changed while held");

    // A refused request reports an error with zeroed fields
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |->
            (o_error && o_timer_state == ST_STOPPED && o_elapsed_time == '0))
        else $error("refused request with non-zero report");

    // Bank write only happens as a result is taken into the output register
    a_write_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_out_valid)
        else $error("bank write without a result");
`endif

endmodule

/* verif/timer_report_board.sv */
`timescale 1ns / 1ps

package stbk_tb_pkg;

    import stbk_pkg::*;

    // Shadow copy of the timer bank plus the queue of reports it still owes.
    class timer_report_board;

        t_status                 status_of [NUM_TIMERS_DEF];
        logic [DATA_W-1:0]       stamp_of  [NUM_TIMERS_DEF];
        logic [DATA_W-1:0]       elapsed_of[NUM_TIMERS_DEF];
        logic [DATA_W-1:0]       limit_of  [NUM_TIMERS_DEF];
        logic [TYPE_MAP_W-1:0]   type_map;
        t_result                 pending_reports[$];
        int                      faults;

        function new();
            for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
                status_of[t]  = ST_STOPPED;
                stamp_of[t]   = '0;
                elapsed_of[t] = '0;
                limit_of[t]   = '0;
            end
            type_map = '0;
            faults   = 0;
        endfunction

        // Apply one accepted request beat to the shadow bank; queue its report.
        function void apply_request(t_req op, logic [ID_W-1:0] id,
                                    logic [DATA_W-1:0] tmo, logic [DATA_W-1:0] fine,
                                    logic [DATA_W-1:0] tick);
            t_result           rep;
            logic              on_ms;
            logic [DATA_W-1:0] span;
            int                t;
            rep = '0;
            if (id >= NUM_TIMERS_DEF) begin
                rep.error = 1'b1;
                pending_reports.push_back(rep);
                return;
            end
            t     = int'(id);
            on_ms = (t < TYPE_MAP_W) ? type_map[t] : 1'b0;
            case (op)
                REQ_START: begin
                    if (status_of[t] == ST_RUNNING) begin
                        rep.error = 1'b1;
                        pending_reports.push_back(rep);
                        return;
                    end
                    status_of[t] = ST_RUNNING;
                    limit_of[t]  = tmo;
                    stamp_of[t]  = on_ms ? tick : fine;
                end
                REQ_CLEAR: begin
                    status_of[t]  = ST_STOPPED;
                    stamp_of[t]   = '0;
                    elapsed_of[t] = '0;
                    limit_of[t]   = '0;
                end
                REQ_CHECK: begin
                    if (status_of[t] != ST_STOPPED) begin
                        // fine base counts down, so the span is stamp minus now, halved
                        span = on_ms ? tick - stamp_of[t] : (stamp_of[t] - fine) >> 1;
                        elapsed_of[t] = span;
                        if (status_of[t] == ST_RUNNING && span >= limit_of[t])
                            status_of[t] = ST_EXPIRED;
                    end
                end
                default: begin
                    rep.error = 1'b1;
                end
            endcase
            rep.report_valid = 1'b1;
            rep.state        = status_of[t];
            rep.elapsed      = elapsed_of[t];
            pending_reports.push_back(rep);
        endfunction

        // Compare one report beat with the oldest outstanding one.
        function void check_report(t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected report: err=%0b rv=%0b st=%0d el=%h",
                             got.error, got.report_valid, got.state, got.elapsed);
                return;
            end
            want = pending_reports.pop_front();
            if (got.error !== want.error || got.report_valid !== want.report_valid ||
                got.state !== want.state || got.elapsed !== want.elapsed) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: want %0b/%0b/%0d/%h got %0b/%0b/%0d/%h",
                             want.error, want.report_valid, want.state, want.elapsed,
                             got.error, got.report_valid, got.state, got.elapsed);
            end
        endfunction

    endclass

endpackage

/* verif/software_timer_bank_core_tb.sv */
`timescale 1ns / 1ps

module software_timer_bank_core_tb;

    import stbk_pkg::*;
    import stbk_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [TYPE_MAP_W-1:0] cfg_wr_data = '0;

    logic                  in_valid = 1'b0;
    logic [1:0]            req_type = 2'd0;
    logic [ID_W-1:0]       timer_id = '0;
    logic [DATA_W-1:0]     timeout_value = '0;
    logic [DATA_W-1:0]     fine_count = '0;
    logic [DATA_W-1:0]     ms_tick = '0;
    logic                  out_stall = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_error;
    logic                  o_report_valid;
    logic [1:0]            o_timer_state;
    logic [DATA_W-1:0]     o_elapsed_time;

    timer_report_board     board;

    // When set, neither side idles: a long stretch at full rate.
    bit                    calm = 1'b0;
    int                    quiet_cycles = 0;

    // Free-running views of the two time bases, advanced per request.
    logic [DATA_W-1:0]     fine_now;
    logic [DATA_W-1:0]     tick_now;

    software_timer_bank_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (req_type),
        .i_timer_id      (timer_id),
        .i_timeout_value (timeout_value),
        .i_fine_count    (fine_count),
        .i_ms_tick       (ms_tick),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_error         (o_error),
        .o_report_valid  (o_report_valid),
        .o_timer_state   (o_timer_state),
        .o_elapsed_time  (o_elapsed_time)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Report side: check each accepted beat, then pick the stall for the next cycle.
    // Values read here are those present at the edge, since all updates are nonblocking.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got.error        = o_error;
            got.report_valid = o_report_valid;
            got.state        = t_status'(o_timer_state);
            got.elapsed      = o_elapsed_time;
            board.check_report(got);
        end
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[software_timer_bank_core] ERROR");
                $finish;
            end
        end
    end

    // Present one request beat and hold it until the block takes it.
    // Unless calm is set, each cycle before the beat idles with a 22 in 100 chance.
    task automatic send_request(input t_req op, input logic [ID_W-1:0] id,
                                input logic [DATA_W-1:0] tmo, input logic [DATA_W-1:0] fine,
                                input logic [DATA_W-1:0] tick);
        while (!calm && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        req_type      <= op;
        timer_id      <= id;
        timeout_value <= tmo;
        fine_count    <= fine;
        ms_tick       <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.apply_request(op, id, tmo, fine, tick);
    endtask

    // Drop valid and hold until every outstanding report has come back.
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Write the type map; only called with the block drained.
    task automatic write_type_map(input logic [TYPE_MAP_W-1:0] map);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= map;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        board.type_map = map;
    endtask

    // Drain, let the two pipeline stages settle, then switch the type map.
    task automatic next_phase(input logic [TYPE_MAP_W-1:0] map);
        wait_for_reports();
        repeat (3) @(posedge i_clk);
        write_type_map(map);
    endtask

    // Mostly coherent timer traffic: time bases move forward, timeouts are small
    // enough that timers expire, with jumps, noise and bad ids mixed in.
    task automatic random_requests(input int count);
        t_req              op;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] tmo;
        logic [DATA_W-1:0] fine;
        logic [DATA_W-1:0] tick;
        int                roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      op = REQ_START;
            else if (roll < 72) op = REQ_CHECK;
            else if (roll < 88) op = REQ_CLEAR;
            else                op = REQ_INVALID;

            // bursts on two timers exercise the forwarding around the bank
            if ($urandom_range(0, 99) < 8)
                id = ID_W'($urandom_range(NUM_TIMERS_DEF, 255));
            else if ((n % 100) < 20)
                id = ID_W'($urandom_range(0, 1));
            else
                id = ID_W'($urandom_range(0, NUM_TIMERS_DEF - 1));

            roll = $urandom_range(0, 99);
            if (roll < 6)       tmo = '0;
            else if (roll < 12) tmo = '1;
            else if (roll < 25) tmo = $urandom;
            else                tmo = $urandom_range(0, 120);

            // advance both bases; now and then jump to anywhere in the range
            fine_now = fine_now - $urandom_range(0, 64);
            tick_now = tick_now + $urandom_range(0, 4);
            if ($urandom_range(0, 49) == 0) begin
                fine_now = $urandom;
                tick_now = $urandom;
            end
            fine = fine_now;
            tick = tick_now;
            // occasional noise that has nothing to do with the running time
            if ($urandom_range(0, 19) == 0) begin
                fine = $urandom;
                tick = $urandom;
            end

            send_request(op, id, tmo, fine, tick);

            if ($urandom_range(0, 63) == 0)
                wait_for_reports();
        end
    endtask

    initial begin
        board    = new();
        fine_now = $urandom;
        tick_now = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Timer 15 on the millisecond tick, the rest on the fine counter.
        write_type_map(16'h8000);

        // Directed: stopped check, fine-base wrap, refused start, expiry and
        // recompute while expired, restart of an expired timer, zero limit.
        send_request(REQ_CHECK,   8'd0,  32'd0,          32'd0,          32'd0);
        send_request(REQ_START,   8'd0,  32'd100,        32'h0000_0010,  32'd0);
        send_request(REQ_START,   8'd0,  32'd5,          32'h0000_0000,  32'd0);
        send_request(REQ_CHECK,   8'd0,  32'd0,          32'hFFFF_FFF0,  32'd0);
        send_request(REQ_CHECK,   8'd0,  32'd0,          32'hFFFF_FF00,  32'd0);
        send_request(REQ_CHECK,   8'd0,  32'd0,          32'h0000_0000,  32'd0);
        send_request(REQ_START,   8'd0,  32'd0,          32'hFFFF_FFFF,  32'd0);
        send_request(REQ_CHECK,   8'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_request(REQ_INVALID, 8'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_request(REQ_CLEAR,   8'd0,  32'd0,          32'd0,          32'd0);
        send_request(REQ_CHECK,   8'd0,  32'd0,          32'h1234_5678,  32'd0);
        // millisecond base, maximum limit, tick wrapping through zero
        send_request(REQ_START,   8'd15, 32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFE);
        send_request(REQ_CHECK,   8'd15, 32'd0,          32'd0,          32'h0000_0003);
        send_request(REQ_CHECK,   8'd15, 32'd0,          32'd0,          32'hFFFF_FFFD);
        send_request(REQ_INVALID, 8'd15, 32'd0,          32'd0,          32'd0);
        send_request(REQ_CLEAR,   8'd15, 32'd0,          32'd0,          32'd0);
        // ids past the bank, including the top of the field
        send_request(REQ_START,   8'd16, 32'd10,         32'd0,          32'd0);
        send_request(REQ_CHECK,   8'd255, 32'd0,         32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_request(REQ_INVALID, 8'd200, 32'd0,         32'd0,          32'd0);
        send_request(REQ_CLEAR,   8'd128, 32'd0,         32'd0,          32'd0);
        // zero limit expires at once; clearing a stopped timer
        send_request(REQ_START,   8'd1,  32'd0,          32'd5,          32'd0);
        send_request(REQ_CHECK,   8'd1,  32'd0,          32'd5,          32'd0);
        send_request(REQ_CLEAR,   8'd3,  32'd0,          32'd0,          32'd0);
        send_request(REQ_START,   8'd7,  32'h8000_0000,  32'hAAAA_AAAA,  32'h5555_5555);
        send_request(REQ_CHECK,   8'd7,  32'd0,          32'h5555_5555,  32'hAAAA_AAAA);

        // Random phases across several type maps, extremes first.
        next_phase(16'h0000);
        random_requests(200);

        next_phase(16'hFFFF);
        calm = 1'b1;
        random_requests(200);
        calm = 1'b0;

        next_phase(16'hA5C3);
        random_requests(250);

        next_phase(TYPE_MAP_W'($urandom));
        random_requests(250);

        wait_for_reports();
        repeat (4) @(posedge i_clk);

        if (board.pending_reports.size() != 0) begin
            $display("%0d reports never arrived", board.pending_reports.size());
            board.faults++;
        end
        if (board.faults == 0)
            $display("[software_timer_bank_core] OK");
        else
            $display("[software_timer_bank_core] ERROR");
        $finish;
    end

endmodule
